// File: hw/rtl/world_point_screen_projection_macros.svh
// Assertion macros for the RTL files; wpsp_scr includes them.
`ifndef WORLD_POINT_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_POINT_SCREEN_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpsp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpsp assertion failed");

`endif

// File: hw/rtl/wpsp_pkg.sv
package wpsp_pkg;

    localparam int FRAC     = 16;
    localparam int COORD_W  = 32;
    localparam int NUM_REGS = 8;
    localparam int RIDX_W   = $clog2(NUM_REGS);
    localparam int REG_W    = 2 * COORD_W;
    localparam int NUM_ELEM = 2 * NUM_REGS;

    localparam int PROD_W = 2 * COORD_W;
    localparam int FL_W   = PROD_W - FRAC;
    localparam int CLIP_W = FL_W + 2;

    localparam int IP_LOG = 24;
    localparam int QW     = IP_LOG + FRAC;
    localparam int STEPS  = 2;
    localparam int DSTG   = (QW + STEPS - 1) / STEPS;

    localparam logic signed [CLIP_W-1:0] THRESH = CLIP_W'(((1 << FRAC) + 5) / 10);

    localparam int VIEW_HW = 512;
    localparam int VIEW_HH = 384;
    localparam int X_BIAS  = 5;
    localparam int Y_BIAS  = 16;
    localparam int SX_OFF  = VIEW_HW + X_BIAS;
    localparam int SX_SCL  = VIEW_HW + 1;
    localparam int SY_OFF  = VIEW_HH - Y_BIAS;
    localparam int SY_SCL  = VIEW_HH - 1;
    localparam int SCL_W   = 12;
    localparam int NDC_W   = QW + 2;
    localparam int SUM_W   = NDC_W + SCL_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cz;
        logic signed [CLIP_W-1:0] cw;
    } t_clip;

    typedef struct packed {
        logic visible;
        logic wzero;
        logic cx_pos;
        logic cy_pos;
        logic neg_x;
        logic neg_y;
        logic big_x;
        logic big_y;
    } t_dflg;

    typedef struct packed {
        t_dflg           flg;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
    } t_ndc;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      overflow;
    } t_screen;

endpackage

// File: hw/rtl/wpsp_point_if.sv
interface wpsp_point_if import wpsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: hw/rtl/wpsp_screen_if.sv
interface wpsp_screen_if import wpsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      visible;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic                      overflow;

    modport source (output valid, visible, screen_x, screen_y, overflow, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, overflow, output ready);
endinterface

// File: hw/rtl/world_point_screen_projection.sv
// Channel   Role  Transaction payload
// i_pt      in    point_x, point_y, point_z (signed Q16.16 world point)
// o_scr     out   visible, screen_x, screen_y (signed Q16.16), overflow
// i_cfg_*   in    eight 64-bit matrix registers, two elements each
//
// One point enters per cycle while o_scr is not stalled; the pipeline is the
// three matrix stages, the restoring divider of two quotient bits per stage and
// the two screen-mapping stages. A full pipeline holds one transaction per stage.
// Reset is synchronous and active low; it clears the valid bits and the matrix.
// Each stage loads when it is empty or the stage after it moves, so a stall on
// o_scr fills bubbles first and never loses or repeats a transaction.
module world_point_screen_projection import wpsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RIDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]  i_cfg_data,
    wpsp_point_if.sink        i_pt,
    wpsp_screen_if.source     o_scr
);
    t_point  pt;
    t_clip   clip;
    t_ndc    ndc;
    t_screen scr;
    logic    clip_v, clip_r, ndc_v, ndc_r;

    assign pt.point_x = i_pt.point_x;
    assign pt.point_y = i_pt.point_y;
    assign pt.point_z = i_pt.point_z;

    // Clip coordinates: products, then a two-level adder tree.
    wpsp_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_pt.valid),
        .o_ready    (i_pt.ready),
        .i_pt       (pt),
        .o_valid    (clip_v),
        .i_ready    (clip_r),
        .o_clip     (clip)
    );

    // Visibility test and the two perspective quotients.
    wpsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (clip_v),
        .o_ready (clip_r),
        .i_clip  (clip),
        .o_valid (ndc_v),
        .i_ready (ndc_r),
        .o_ndc   (ndc)
    );

    // Viewport mapping, saturation and the output register.
    wpsp_scr u_scr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ndc_v),
        .o_ready (ndc_r),
        .i_ndc   (ndc),
        .o_valid (o_scr.valid),
        .i_ready (o_scr.ready),
        .o_scr   (scr)
    );

    assign o_scr.visible  = scr.visible;
    assign o_scr.screen_x = scr.screen_x;
    assign o_scr.screen_y = scr.screen_y;
    assign o_scr.overflow = scr.overflow;
endmodule

// File: hw/rtl/wpsp_mac.sv
module wpsp_mac import wpsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RIDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_point            i_pt,
    output logic              o_valid,
    input  logic              i_ready,
    output t_clip             o_clip
);
    localparam int NS = 3;

    logic [REG_W-1:0]          r_mat [NUM_REGS];
    logic signed [COORD_W-1:0] m     [NUM_ELEM];
    logic [NS-1:0]             r_v;
    logic [NS:0]               en;

    logic signed [PROD_W-1:0]  r_p [4][3];
    logic signed [COORD_W-1:0] r_t [4];
    logic signed [CLIP_W-1:0]  r_a [4];
    logic signed [CLIP_W-1:0]  r_b [4];
    logic signed [CLIP_W-1:0]  r_c [4];

    // Floor to the working fraction: an arithmetic shift rounds towards minus infinity.
    function automatic logic signed [CLIP_W-1:0] fl(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC;
        return CLIP_W'(sh);
    endfunction

    always_comb begin
        for (int j = 0; j < NUM_REGS; j++) begin
            m[2*j]   = r_mat[j][COORD_W-1:0];
            m[2*j+1] = r_mat[j][REG_W-1:COORD_W];
        end
    end

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            for (int j = 0; j < NUM_REGS; j++) begin
                r_mat[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mat[i_cfg_idx] <= i_cfg_data;
            end
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            if (en[0]) begin
                r_p[r][0] <= PROD_W'(i_pt.point_x) * PROD_W'(m[r]);
                r_p[r][1] <= PROD_W'(i_pt.point_y) * PROD_W'(m[r+4]);
                r_p[r][2] <= PROD_W'(i_pt.point_z) * PROD_W'(m[r+8]);
                r_t[r]    <= m[r+12];
            end
            if (en[1]) begin
                r_a[r] <= fl(r_p[r][0]) + fl(r_p[r][1]);
                r_b[r] <= fl(r_p[r][2]) + CLIP_W'(r_t[r]);
            end
            if (en[2]) begin
                r_c[r] <= r_a[r] + r_b[r];
            end
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_v[NS-1];
    assign o_clip.cx   = r_c[0];
    assign o_clip.cy   = r_c[1];
    assign o_clip.cz   = r_c[2];
    assign o_clip.cw   = r_c[3];
endmodule

// File: hw/rtl/wpsp_div.sv
module wpsp_div import wpsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_clip i_clip,
    output logic  o_valid,
    input  logic  i_ready,
    output t_ndc  o_ndc
);
    localparam int NS = DSTG + 1;

    typedef struct packed {
        t_dflg             flg;
        logic [CLIP_W-1:0] b;
        logic [CLIP_W-1:0] rx;
        logic [CLIP_W-1:0] ry;
        logic [QW-1:0]     nx;
        logic [QW-1:0]     ny;
        logic [QW-1:0]     qx;
        logic [QW-1:0]     qy;
    } t_dst;

    typedef struct packed {
        logic [CLIP_W-1:0] r;
        logic [QW-1:0]     n;
        logic [QW-1:0]     q;
    } t_part;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;
    t_dst          r_st [NS];
    t_dst          n_st [NS];

    logic [CLIP_W-1:0] ax, ay, bw, ux, uy;

    function automatic logic [CLIP_W-1:0] mag(input logic signed [CLIP_W-1:0] v);
        return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
    endfunction

    // One restoring step: bring down the next numerator bit, subtract if it fits.
    function automatic t_part dstep(input t_part p, input logic [CLIP_W-1:0] b);
        t_part             o;
        logic [CLIP_W:0]   t;
        t = {p.r, p.n[QW-1]};
        o.n = {p.n[QW-2:0], 1'b0};
        if (t >= {1'b0, b}) begin
            o.r = CLIP_W'(t - {1'b0, b});
            o.q = {p.q[QW-2:0], 1'b1};
        end else begin
            o.r = t[CLIP_W-1:0];
            o.q = {p.q[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        t_part px, py;
        ax = mag(i_clip.cx);
        ay = mag(i_clip.cy);
        bw = mag(i_clip.cw);
        n_st[0].flg.visible = (i_clip.cz >= THRESH);
        n_st[0].flg.wzero   = (i_clip.cw == '0);
        n_st[0].flg.cx_pos  = !i_clip.cx[CLIP_W-1];
        n_st[0].flg.cy_pos  = !i_clip.cy[CLIP_W-1];
        n_st[0].flg.neg_x   = i_clip.cx[CLIP_W-1] ^ i_clip.cw[CLIP_W-1];
        n_st[0].flg.neg_y   = i_clip.cy[CLIP_W-1] ^ i_clip.cw[CLIP_W-1];
        // Integer part at or above the cap: the screen value saturates anyway.
        n_st[0].flg.big_x   = ((CLIP_W + IP_LOG)'(ax) >= {bw, IP_LOG'(0)});
        n_st[0].flg.big_y   = ((CLIP_W + IP_LOG)'(ay) >= {bw, IP_LOG'(0)});
        ux = n_st[0].flg.big_x ? '0 : ax;
        uy = n_st[0].flg.big_y ? '0 : ay;
        n_st[0].b  = bw;
        n_st[0].rx = ux >> IP_LOG;
        n_st[0].ry = uy >> IP_LOG;
        n_st[0].nx = {ux[IP_LOG-1:0], FRAC'(0)};
        n_st[0].ny = {uy[IP_LOG-1:0], FRAC'(0)};
        n_st[0].qx = '0;
        n_st[0].qy = '0;
        for (int k = 1; k < NS; k++) begin
            n_st[k] = r_st[k-1];
            px = '{r: r_st[k-1].rx, n: r_st[k-1].nx, q: r_st[k-1].qx};
            py = '{r: r_st[k-1].ry, n: r_st[k-1].ny, q: r_st[k-1].qy};
            for (int s = 0; s < STEPS; s++) begin
                if ((k - 1) * STEPS + s < QW) begin
                    px = dstep(px, r_st[k-1].b);
                    py = dstep(py, r_st[k-1].b);
                end
            end
            n_st[k].rx = px.r;
            n_st[k].nx = px.n;
            n_st[k].qx = px.q;
            n_st[k].ry = py.r;
            n_st[k].ny = py.n;
            n_st[k].qy = py.q;
        end
    end

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready   = en[0];
    assign o_valid   = r_v[NS-1];
    assign o_ndc.flg = r_st[NS-1].flg;
    assign o_ndc.qx  = r_st[NS-1].qx;
    assign o_ndc.qy  = r_st[NS-1].qy;
endmodule

// File: hw/rtl/wpsp_scr.sv
`include "world_point_screen_projection_macros.svh"

module wpsp_scr import wpsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_ndc    i_ndc,
    output logic    o_valid,
    input  logic    i_ready,
    output t_screen o_scr
);
    localparam int NS = 2;
    localparam logic signed [SCL_W-1:0] KX = SCL_W'(SX_SCL);
    localparam logic signed [SCL_W-1:0] KY = SCL_W'(SY_SCL);
    localparam logic signed [SUM_W-1:0] OX = SUM_W'(SX_OFF) <<< FRAC;
    localparam logic signed [SUM_W-1:0] OY = SUM_W'(SY_OFF) <<< FRAC;
    localparam logic signed [SUM_W-1:0] SMAX = {{(SUM_W-COORD_W+1){1'b0}},
                                                {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;
    localparam logic signed [COORD_W-1:0] OMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] OMIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [NS-1:0]            r_v;
    logic [NS:0]              en;
    logic [QW:0]              mx, my;
    logic signed [NDC_W-1:0]  nx, ny;
    logic signed [SUM_W-1:0]  r_px, r_py, sx, sy;
    t_dflg                    r_flg;
    t_screen                  n_out, r_out;
    logic                     ox, oy;

    always_comb begin
        mx = i_ndc.flg.big_x ? (QW+1)'(1) << QW : {1'b0, i_ndc.qx};
        my = i_ndc.flg.big_y ? (QW+1)'(1) << QW : {1'b0, i_ndc.qy};
        nx = i_ndc.flg.neg_x ? -NDC_W'(mx) : NDC_W'(mx);
        ny = i_ndc.flg.neg_y ? -NDC_W'(my) : NDC_W'(my);
    end

    always_comb begin
        sx = OX + r_px;
        sy = OY - r_py;
        ox = (sx > SMAX) || (sx < SMIN);
        oy = (sy > SMAX) || (sy < SMIN);
        n_out = '0;
        if (r_flg.visible) begin
            n_out.visible = 1'b1;
            if (r_flg.wzero) begin
                n_out.screen_x = r_flg.cx_pos ? OMAX : OMIN;
                n_out.screen_y = r_flg.cy_pos ? OMIN : OMAX;
                n_out.overflow = 1'b1;
            end else begin
                n_out.screen_x = (sx > SMAX) ? OMAX : (sx < SMIN) ? OMIN : COORD_W'(sx);
                n_out.screen_y = (sy > SMAX) ? OMAX : (sy < SMIN) ? OMIN : COORD_W'(sy);
                n_out.overflow = ox || oy;
            end
        end
    end

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            if (en[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_px  <= SUM_W'(nx) * SUM_W'(KX);
            r_py  <= SUM_W'(ny) * SUM_W'(KY);
            r_flg <= i_ndc.flg;
        end
        if (en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_scr   = r_out;

    `WPSP_ASSERT_NOW(a_hidden_zero, i_clk, i_rst_n, o_valid && !o_scr.visible,
        o_scr.screen_x == '0 && o_scr.screen_y == '0 && !o_scr.overflow)
    `WPSP_ASSERT_NEXT(a_take_in, i_clk, i_rst_n, i_valid && o_ready, r_v[0])
    `WPSP_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, r_v[0] && !en[1], r_v[0])
    `WPSP_ASSERT_NEXT(a_wzero_ovf, i_clk, i_rst_n,
        r_v[0] && en[1] && r_flg.visible && r_flg.wzero, r_out.overflow)
endmodule
